/* design/cfsb_pkg.sv */
`default_nettype none

package cfsb_pkg;

    localparam int FRAME_WIDTH  = 32;
    localparam int FRAME_HEIGHT = 16;
    localparam int SPRITE_DIM   = 3;

    localparam int FRAME_CELLS = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int SPR_CELLS   = SPRITE_DIM * SPRITE_DIM;

    localparam int ADDR_W    = $clog2(FRAME_CELLS);
    localparam int COL_W     = $clog2(FRAME_WIDTH);
    localparam int ROW_W     = $clog2(FRAME_HEIGHT);
    localparam int SPR_IDX_W = $clog2(SPR_CELLS);
    localparam int SPR_POS_W = $clog2(SPRITE_DIM);

    localparam logic [7:0] KEY_RESET      = 8'd37;
    localparam logic [7:0] SPR_RESET_BASE = 8'h31;

    typedef enum logic [2:0] {
        ACT_FILL   = 3'd0,
        ACT_BORDER = 3'd1,
        ACT_LOAD   = 3'd2,
        ACT_ROTATE = 3'd3,
        ACT_BLIT   = 3'd4,
        ACT_READ   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_HALF = 2'd2,
        ROT_CCW  = 2'd3
    } t_rotation;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_FILL,
        S_BORDER,
        S_BLIT,
        S_READ_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                 load;
        logic                 rotate;
        t_rotation            rot;
        logic [SPR_IDX_W-1:0] idx;
        logic [7:0]           data;
    } t_spr_cmd;

endpackage

`default_nettype wire

/* design/char_framebuffer_sprite_blitter_core.sv */
// Character frame store with a 3x3 sprite blitter and a transparent key.
// Requests come in on the i_in_valid / o_in_ready channel, one command per
// request; every request yields exactly one result on o_out_valid /
// i_out_ready, in order. The user writes the key register with i_key_we and
// i_key_wdata only while the block is idle; the block does not enforce this.
// A request is taken only while the sequencer is idle. Each request passes
// through decode and ends in a done step; load, rotate and unused commands go
// straight from decode to done, a read of a valid cell first waits for the
// frame data, a blit walks the sprite one cell per cycle, and fill and border
// walk every frame cell through the single write port of the frame memory.
// The result is loaded into the output register as the sequencer leaves its
// done step for idle, so the block is ready for the next request in the same
// cycle as the result appears.
// If the receiver stalls, the result waits in the output register while the
// next request is accepted and worked on; that request then holds in its
// final step until the output register frees up.
// Reset is synchronous: it sets the key to '%' and the sprite to the digits
// '1' through '9'. The frame memory is not cleared and must be written before
// it is read.
`default_nettype none

module char_framebuffer_sprite_blitter_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [2:0]        i_action,
    input  wire logic [7:0]        i_fill_char,
    input  wire logic signed [7:0] i_pos_x,
    input  wire logic signed [7:0] i_pos_y,
    input  wire logic [4:0]        i_cell_x,
    input  wire logic [3:0]        i_cell_y,
    input  wire logic [1:0]        i_rotation,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic      [7:0]        o_read_char,
    output logic                   o_bad_coordinate,
    input  wire logic              i_key_we,
    input  wire logic [7:0]        i_key_wdata
);

    import cfsb_pkg::*;

    t_state r_state;
    t_state n_state;

    t_action           r_action;
    logic [7:0]        r_char;
    logic signed [7:0] r_pos_x;
    logic signed [7:0] r_pos_y;
    logic [4:0]        r_cell_x;
    logic [3:0]        r_cell_y;
    t_rotation         r_rot;
    logic [7:0]        r_key;

    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [SPR_POS_W-1:0] r_bc;
    logic [SPR_POS_W-1:0] r_br;

    logic [7:0] r_res_char;
    logic       r_res_bad;
    logic       r_out_valid;
    logic [7:0] r_out_char;
    logic       r_out_bad;

    logic              accept;
    logic              walk_last;
    logic              is_border;
    logic              blit_last;
    logic              read_ok;
    logic              load_ok;
    logic              slot_free;
    logic signed [9:0] fx;
    logic signed [9:0] fy;
    logic              blit_in;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    t_spr_cmd             spr_cmd;
    logic [SPR_IDX_W-1:0] spr_rd_idx;
    logic [7:0]           spr_rd_data;

    assign accept    = i_in_valid && o_in_ready;
    assign slot_free = !r_out_valid || i_out_ready;

    assign walk_last = (r_row == ROW_W'(FRAME_HEIGHT - 1)) && (r_col == COL_W'(FRAME_WIDTH - 1));
    assign is_border = (r_row == '0) || (r_row == ROW_W'(FRAME_HEIGHT - 1))
                    || (r_col == '0) || (r_col == COL_W'(FRAME_WIDTH - 1));
    assign blit_last = (r_br == SPR_POS_W'(SPRITE_DIM - 1))
                    && (r_bc == SPR_POS_W'(SPRITE_DIM - 1));

    assign read_ok = (int'(r_cell_x) < FRAME_WIDTH) && (int'(r_cell_y) < FRAME_HEIGHT);
    assign load_ok = (int'(r_cell_x) < SPRITE_DIM) && (int'(r_cell_y) < SPRITE_DIM);

    // Frame coordinates of the sprite cell under the blit counters.
    assign fx = {{2{r_pos_x[7]}}, r_pos_x} + 10'(r_bc);
    assign fy = {{2{r_pos_y[7]}}, r_pos_y} + 10'(r_br);
    assign blit_in = !fx[9] && !fy[9] && (int'(fx) < FRAME_WIDTH) && (int'(fy) < FRAME_HEIGHT);

    assign spr_rd_idx = SPR_IDX_W'(int'(r_br) * SPRITE_DIM + int'(r_bc));
    assign ram_raddr  = ADDR_W'(int'(r_cell_y) * FRAME_WIDTH + int'(r_cell_x));

    cfsb_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_CELLS)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cfsb_sprite u_sprite (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (spr_cmd),
        .i_rd_idx  (spr_rd_idx),
        .o_rd_data (spr_rd_data)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_action)
                    ACT_FILL:   n_state = S_FILL;
                    ACT_BORDER: n_state = S_BORDER;
                    ACT_BLIT:   n_state = S_BLIT;
                    ACT_READ:   n_state = read_ok ? S_READ_WAIT : S_DONE;
                    default:    n_state = S_DONE;
                endcase
            end
            S_FILL, S_BORDER: begin
                if (walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_BLIT: begin
                if (blit_last) begin
                    n_state = S_DONE;
                end
            end
            S_READ_WAIT: n_state = S_DONE;
            S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(int'(r_row) * FRAME_WIDTH + int'(r_col));
        ram_wdata = r_char;
        spr_cmd   = '{load: 1'b0, rotate: 1'b0, rot: r_rot,
                      idx: SPR_IDX_W'(int'(r_cell_y) * SPRITE_DIM + int'(r_cell_x)),
                      data: r_char};
        case (r_state)
            S_FILL: ram_we = 1'b1;
            S_BORDER: ram_we = is_border;
            S_BLIT: begin
                ram_we    = blit_in && (spr_rd_data != r_key);
                ram_waddr = ADDR_W'(int'(fy) * FRAME_WIDTH + int'(fx));
                ram_wdata = spr_rd_data;
            end
            S_DECODE: begin
                spr_cmd.load   = (r_action == ACT_LOAD) && load_ok;
                spr_cmd.rotate = (r_action == ACT_ROTATE);
            end
            default: ram_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key       <= KEY_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_key_we) begin
                r_key <= i_key_wdata;
            end
            if (r_state == S_DONE && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_char   <= i_fill_char;
            r_pos_x  <= i_pos_x;
            r_pos_y  <= i_pos_y;
            r_cell_x <= i_cell_x;
            r_cell_y <= i_cell_y;
            r_rot    <= t_rotation'(i_rotation);
            r_col    <= '0;
            r_row    <= '0;
            r_bc     <= '0;
            r_br     <= '0;
        end else if (r_state == S_FILL || r_state == S_BORDER) begin
            if (r_col == COL_W'(FRAME_WIDTH - 1)) begin
                r_col <= '0;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end else if (r_state == S_BLIT) begin
            if (r_bc == SPR_POS_W'(SPRITE_DIM - 1)) begin
                r_bc <= '0;
                r_br <= r_br + 1'b1;
            end else begin
                r_bc <= r_bc + 1'b1;
            end
        end

        if (r_state == S_DECODE) begin
            r_res_char <= 8'd0;
            r_res_bad  <= ((r_action == ACT_READ) && !read_ok)
                       || ((r_action == ACT_LOAD) && !load_ok);
        end else if (r_state == S_READ_WAIT) begin
            r_res_char <= ram_rdata;
        end

        if (r_state == S_DONE && slot_free) begin
            r_out_char <= r_res_char;
            r_out_bad  <= r_res_bad;
        end
    end

    assign o_in_ready       = (r_state == S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_read_char      = r_out_char;
    assign o_bad_coordinate = r_out_bad;

    // A flagged coordinate never comes with a character.
    a_bad_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bad_coordinate) |-> (o_read_char == 8'd0))
        else $error("bad coordinate result carries a character");

    // The frame is written only by the fill, border and blit walks.
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_FILL || r_state == S_BORDER || r_state == S_BLIT))
        else $error("frame write outside a write command");

    // The read data is sampled in the cycle after the address was set up in decode.
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ_WAIT) |-> ($past(r_state) == S_DECODE))
        else $error("read data taken without its address cycle");

    // An accepted request is always decoded in the following cycle.
    a_accept_decode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");

    // A pending result is never overwritten while the receiver stalls.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_read_char)
                                          && $stable(o_bad_coordinate)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

/* design/cfsb_ram.sv */
`default_nettype none

module cfsb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* design/cfsb_sprite.sv */
`default_nettype none

module cfsb_sprite (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cfsb_pkg::t_spr_cmd            i_cmd,
    input  wire logic [cfsb_pkg::SPR_IDX_W-1:0] i_rd_idx,
    output logic      [7:0]                    o_rd_data
);

    import cfsb_pkg::*;

    localparam int M = SPRITE_DIM - 1;

    logic [7:0] r_cells [SPR_CELLS];
    logic [7:0] n_cells [SPR_CELLS];

    always_comb begin
        n_cells = r_cells;
        if (i_cmd.load) begin
            n_cells[i_cmd.idx] = i_cmd.data;
        end else if (i_cmd.rotate) begin
            for (int r = 0; r < SPRITE_DIM; r++) begin
                for (int c = 0; c < SPRITE_DIM; c++) begin
                    case (i_cmd.rot)
                        ROT_CW:   n_cells[c * SPRITE_DIM + (M - r)] = r_cells[r * SPRITE_DIM + c];
                        ROT_HALF: n_cells[(M - r) * SPRITE_DIM + (M - c)] =
                                      r_cells[r * SPRITE_DIM + c];
                        ROT_CCW:  n_cells[(M - c) * SPRITE_DIM + r] = r_cells[r * SPRITE_DIM + c];
                        default:  n_cells[r * SPRITE_DIM + c] = r_cells[r * SPRITE_DIM + c];
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SPR_CELLS; i++) begin
                r_cells[i] <= SPR_RESET_BASE + 8'(i);
            end
        end else begin
            r_cells <= n_cells;
        end
    end

    assign o_rd_data = r_cells[i_rd_idx];

endmodule

`default_nettype wire
